/* rtl/mmpw_pkg.sv */
// ----------------------------------------------------------------------------
// mmpw_pkg
// Shared types, constants and helpers of the mecanum pulse width mixer.
// ----------------------------------------------------------------------------
package mmpw_pkg;

  localparam int NumWheels = 4;
  localparam int CmdW      = 8;
  localparam int PulseW    = 11;
  localparam int GainW     = 8;
  localparam int PowerW    = 9;
  localparam int RevW      = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 44;

  localparam int MixW   = 10;  // wheel mix, -300..300
  localparam int MagW   = 9;   // wheel magnitude, 0..300
  localparam int NumW   = 15;  // magnitude times 100
  localparam int QuoW   = 7;   // scaled command, 0..100
  localparam int ProdW  = 23;  // command * power * gain
  localparam int SumW   = 13;

  localparam int DivStages    = 4;
  localparam int BitsPerStage = 2;

  // floor(n / 10000) == (n * RecipMul) >> RecipShift for every n below 2^23
  localparam int               RecipShift = 36;
  localparam int               RecipW     = 2 * ProdW;
  localparam logic [ProdW-1:0] RecipMul   = 23'd6871948;

  localparam logic signed [CmdW-1:0] CmdMax = 8'sd100;
  localparam logic signed [CmdW-1:0] CmdMin = -8'sd100;
  localparam logic [MagW-1:0]        MagFloor = 9'd100;
  localparam logic [NumW-1:0]        Hundred  = 15'd100;

  localparam logic [PulseW-1:0] CenterMin = 11'd1300;
  localparam logic [PulseW-1:0] CenterMax = 11'd1700;
  localparam logic [GainW-1:0]  GainMin   = 8'd20;
  localparam logic [GainW-1:0]  GainMax   = 8'd200;
  localparam logic [PowerW-1:0] PowerMin  = 9'd5;
  localparam logic [PowerW-1:0] PowerMax  = 9'd300;
  localparam logic [SumW-1:0]   PulseMin  = 13'd1000;
  localparam logic [SumW-1:0]   PulseMax  = 13'd2000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCenters  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGains    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReversed = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPower    = 3'd3;

  // reset values
  localparam logic [PulseW-1:0] CenterFrontRst = 11'd1500;
  localparam logic [PulseW-1:0] CenterBackRst  = 11'd1540;
  localparam logic [GainW-1:0]  GainRst        = 8'd100;
  localparam logic [RevW-1:0]   RevRst         = 4'd5;
  localparam logic [PowerW-1:0] PowerRst       = 9'd45;

  typedef struct packed {
    logic signed [CmdW-1:0] strafe_cmd;
    logic signed [CmdW-1:0] forward_cmd;
    logic signed [CmdW-1:0] turn_cmd;
  } in_item_t;

  typedef struct packed {
    logic [PulseW-1:0] pulse_front_left;
    logic [PulseW-1:0] pulse_front_right;
    logic [PulseW-1:0] pulse_back_left;
    logic [PulseW-1:0] pulse_back_right;
  } out_item_t;

  // configuration, already saturated to legal ranges
  typedef struct packed {
    logic [NumWheels-1:0][PulseW-1:0] center;
    logic [NumWheels-1:0][GainW-1:0]  gain;
    logic [RevW-1:0]                  rev;
    logic [PowerW-1:0]                power;
  } cfg_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } mix_lane_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NumWheels-1:0] lane;
    logic [MagW-1:0]           big;
  } div_item_t;

  typedef struct packed {
    logic             neg;
    logic [ProdW-1:0] mag;
  } sc_lane_t;

  function automatic logic signed [CmdW-1:0] sat_cmd(input logic signed [CmdW-1:0] v);
    logic signed [CmdW-1:0] r;
    if (v > CmdMax)      r = CmdMax;
    else if (v < CmdMin) r = CmdMin;
    else                 r = v;
    return r;
  endfunction

  function automatic logic [PulseW-1:0] sat_center(input logic [PulseW-1:0] v);
    logic [PulseW-1:0] r;
    if (v < CenterMin)      r = CenterMin;
    else if (v > CenterMax) r = CenterMax;
    else                    r = v;
    return r;
  endfunction

  function automatic logic [GainW-1:0] sat_gain(input logic [GainW-1:0] v);
    logic [GainW-1:0] r;
    if (v < GainMin)      r = GainMin;
    else if (v > GainMax) r = GainMax;
    else                  r = v;
    return r;
  endfunction

  function automatic logic [PowerW-1:0] sat_power(input logic [PowerW-1:0] v);
    logic [PowerW-1:0] r;
    if (v < PowerMin)      r = PowerMin;
    else if (v > PowerMax) r = PowerMax;
    else                   r = v;
    return r;
  endfunction

  // one restoring divide step for quotient bit j
  function automatic div_lane_t div_step(input div_lane_t l, input logic [MagW-1:0] d,
                                         input int unsigned j);
    logic [NumW:0] sh;
    logic [NumW:0] diff;
    div_lane_t     r;
    r    = l;
    sh   = (NumW+1)'(d) << j;
    diff = {1'b0, l.rem} - sh;
    if (!diff[NumW]) begin
      r.rem    = diff[NumW-1:0];
      r.quo[j] = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/mecanum_mixer_pulse_width.sv */
// ----------------------------------------------------------------------------
// mecanum_mixer_pulse_width
// Mixes a strafe/forward/turn command into four clamped ESC pulse widths.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_item_t  (three 8-bit commands)
//   out_     output     out_valid / out_ready  out_item_t (four 11-bit pulses)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index (3b), cfg_data (44b)
//
// Ten register stages: two for mix and max, four for the divider that scales
// by 100 / largest magnitude, floored at 100 (two quotient bits per stage,
// one in the last), four for the power and gain multiplies, the divide by
// 10000 and the center add with clamp. One item per cycle sustained while
// out_ready is high; an item is registered by every stage before out_valid rises.
// Each stage holds only while the stage after it is full and stalled, so a
// stalled output still lets earlier stages fill up before in_ready drops.
// Synchronous active-low reset clears the valid bits and loads default config.
// ----------------------------------------------------------------------------
module mecanum_mixer_pulse_width
  import mmpw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Config is stored already saturated; the datapath never sees an
  // out-of-range center, gain or power.
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= {CenterBackRst, CenterBackRst, CenterFrontRst, CenterFrontRst};
      cfg_r.gain   <= {GainRst, GainRst, GainRst, GainRst};
      cfg_r.rev    <= RevRst;
      cfg_r.power  <= PowerRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegCenters: begin
          for (int i = 0; i < NumWheels; i++) begin
            cfg_r.center[i] <= sat_center(cfg_data[PulseW*i +: PulseW]);
          end
        end
        RegGains: begin
          for (int i = 0; i < NumWheels; i++) begin
            cfg_r.gain[i] <= sat_gain(cfg_data[GainW*i +: GainW]);
          end
        end
        RegReversed: cfg_r.rev   <= cfg_data[RevW-1:0];
        RegPower:    cfg_r.power <= sat_power(cfg_data[PowerW-1:0]);
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // mix -> divider -> scale
  logic      mix_valid, mix_ready;
  div_item_t mix_data;
  logic      div_valid, div_ready;
  div_item_t div_data;

  mmpw_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  mmpw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  mmpw_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Input only backs up when every stage is full behind a stalled output.
  a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled output");

  // Scaled commands never exceed full scale.
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid |-> (div_data.lane[0].quo <= 7'd100 && div_data.lane[1].quo <= 7'd100 &&
                   div_data.lane[2].quo <= 7'd100 && div_data.lane[3].quo <= 7'd100))
    else $error("divider quotient above 100");

  // A delivered item always holds legal pulse widths.
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pulse_front_left  >= 11'd1000 &&
                   out_data.pulse_front_left  <= 11'd2000 &&
                   out_data.pulse_front_right >= 11'd1000 &&
                   out_data.pulse_front_right <= 11'd2000 &&
                   out_data.pulse_back_left   >= 11'd1000 &&
                   out_data.pulse_back_left   <= 11'd2000 &&
                   out_data.pulse_back_right  >= 11'd1000 &&
                   out_data.pulse_back_right  <= 11'd2000))
    else $error("pulse width out of range");

endmodule

/* rtl/mmpw_mix.sv */
// ----------------------------------------------------------------------------
// mmpw_mix
// Two stages: saturate and mix into wheel magnitudes, then find the largest
// magnitude and form the divider numerators.
// ----------------------------------------------------------------------------
module mmpw_mix
  import mmpw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_data
);

  logic                       vld_a_r, vld_b_r;
  logic                       rdy_a, rdy_b;
  mix_lane_t [NumWheels-1:0]  a_r, a_nxt;
  div_item_t                  b_r, b_nxt;

  assign rdy_b    = !vld_b_r || out_ready;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    logic signed [MixW-1:0]           x, y, t;
    logic signed [NumWheels-1:0][MixW-1:0] w;
    x = MixW'(sat_cmd(in_data.strafe_cmd));
    y = MixW'(sat_cmd(in_data.forward_cmd));
    t = MixW'(sat_cmd(in_data.turn_cmd));
    w[0] = y + x + t;
    w[1] = y - x - t;
    w[2] = y - x + t;
    w[3] = y + x - t;
    for (int i = 0; i < NumWheels; i++) begin
      a_nxt[i].neg = w[i][MixW-1];
      a_nxt[i].mag = w[i][MixW-1] ? MagW'(-w[i]) : MagW'(w[i]);
    end
  end

  always_comb begin
    logic [MagW-1:0] m01, m23, m;
    m01 = (a_r[0].mag > a_r[1].mag) ? a_r[0].mag : a_r[1].mag;
    m23 = (a_r[2].mag > a_r[3].mag) ? a_r[2].mag : a_r[3].mag;
    m   = (m01 > m23) ? m01 : m23;
    b_nxt.big = (m > MagFloor) ? m : MagFloor;
    for (int i = 0; i < NumWheels; i++) begin
      b_nxt.lane[i].neg = a_r[i].neg;
      b_nxt.lane[i].rem = NumW'(a_r[i].mag) * Hundred;
      b_nxt.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= in_valid;
      if (rdy_b) vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) a_r <= a_nxt;
    if (rdy_b && vld_a_r)  b_r <= b_nxt;
  end

  assign out_valid = vld_b_r;
  assign out_data  = b_r;

endmodule

/* rtl/mmpw_div.sv */
// ----------------------------------------------------------------------------
// mmpw_div
// Pipelined restoring divider, four lanes, two quotient bits per stage, one in the last.
// ----------------------------------------------------------------------------
module mmpw_div
  import mmpw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_data
);

  logic      [DivStages-1:0] vld_r;
  logic      [DivStages-1:0] rdy;
  div_item_t [DivStages-1:0] stg_r, stg_nxt;

  always_comb begin
    for (int s = DivStages - 1; s >= 0; s--) begin
      if (s == DivStages - 1) rdy[s] = !vld_r[s] || out_ready;
      else                    rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    div_item_t src;
    int        j;
    for (int s = 0; s < DivStages; s++) begin
      src = (s == 0) ? in_data : stg_r[(s == 0) ? 0 : s - 1];
      stg_nxt[s] = src;
      for (int b = 0; b < BitsPerStage; b++) begin
        j = QuoW - 1 - BitsPerStage * s - b;
        if (j >= 0) begin
          for (int l = 0; l < NumWheels; l++) begin
            stg_nxt[s].lane[l] = div_step(stg_nxt[s].lane[l], src.big, j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < DivStages; s++) begin
        if (rdy[s]) vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DivStages; s++) begin
      if (rdy[s] && ((s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s - 1])) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[DivStages-1];
  assign out_data  = stg_r[DivStages-1];

endmodule

/* rtl/mmpw_scale.sv */
// ----------------------------------------------------------------------------
// mmpw_scale
// Four stages: times power, times gain, divide by 10000, then add to the
// wheel center with direction and clamp.
// ----------------------------------------------------------------------------
module mmpw_scale
  import mmpw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [3:0]               vld_r;
  logic [3:0]               rdy;
  sc_lane_t [NumWheels-1:0] c_r, c_nxt, d_r, d_nxt, e_r, e_nxt;
  out_item_t                o_r, o_nxt;

  assign rdy[3] = !vld_r[3] || out_ready;
  assign rdy[2] = !vld_r[2] || rdy[3];
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];

  always_comb begin
    logic [RecipW-1:0] full;
    for (int i = 0; i < NumWheels; i++) begin
      c_nxt[i].neg = in_data.lane[i].neg;
      c_nxt[i].mag = ProdW'(in_data.lane[i].quo) * ProdW'(cfg.power);
      d_nxt[i].neg = c_r[i].neg;
      d_nxt[i].mag = c_r[i].mag * ProdW'(cfg.gain[i]);
      full         = RecipW'(d_r[i].mag) * RecipW'(RecipMul);
      e_nxt[i].neg = d_r[i].neg;
      e_nxt[i].mag = ProdW'(full[RecipW-1:RecipShift]);
    end
  end

  always_comb begin
    logic [NumWheels-1:0][PulseW-1:0] p;
    logic [SumW-1:0]                  c, dl, s;
    for (int i = 0; i < NumWheels; i++) begin
      c  = SumW'(cfg.center[i]);
      dl = e_r[i].mag[SumW-1:0];
      s  = (e_r[i].neg ^ cfg.rev[i]) ? c - dl : c + dl;
      if (s < PulseMin)      p[i] = PulseW'(PulseMin);
      else if (s > PulseMax) p[i] = PulseW'(PulseMax);
      else                   p[i] = s[PulseW-1:0];
    end
    o_nxt.pulse_front_left  = p[0];
    o_nxt.pulse_front_right = p[1];
    o_nxt.pulse_back_left   = p[2];
    o_nxt.pulse_back_right  = p[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) c_r <= c_nxt;
    if (rdy[1] && vld_r[0]) d_r <= d_nxt;
    if (rdy[2] && vld_r[1]) e_r <= e_nxt;
    if (rdy[3] && vld_r[2]) o_r <= o_nxt;
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[3];
  assign out_data  = o_r;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mecanum pulse width mixer: a queue-fed command
// driver, a result monitor scored against a cycle-free prediction of the four
// ESC pulses, and register settings swept between drained traffic phases.
// ----------------------------------------------------------------------------
module tb;
  import mmpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register stages in the pipeline; used for the quiet spell before
  // register writes and at the end of the run.
  localparam int PipeDepth  = 10;
  localparam int IdlePct    = 37;       // chance in percent of an idle cycle
  localparam int MaxReports = 10;
  localparam int TimeoutNs  = 2_000_000;
  localparam int NumRegs    = int'(RegPower) + 1;
  localparam int RandPhases = 8;
  localparam int RandItems  = 90;       // random commands per random phase

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Commands waiting for the driver, and pulse sets waiting for the DUT.
  in_item_t  pending_cmds[$];
  out_item_t expected_pulses[$];

  // Shadow copy of the register file, raw as written (saturation is applied
  // at use; the block saturates on write instead, with the same result).
  logic [NumWheels*PulseW-1:0] centers_reg = {CenterBackRst, CenterBackRst,
                                              CenterFrontRst, CenterFrontRst};
  logic [NumWheels*GainW-1:0]  gains_reg   = {NumWheels{GainRst}};
  logic [RevW-1:0]             rev_reg     = RevRst;
  logic [PowerW-1:0]           power_reg   = PowerRst;

  bit    no_gaps = 1'b0;   // set for one phase: both sides run flat out
  int    errors;
  int    cmds_sent;
  int    pulses_checked;
  int    reg_writes;
  int    settings_used;
  string wheel_name[NumWheels] = '{"FL", "FR", "BL", "BR"};

  mecanum_mixer_pulse_width dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pulse prediction
  // --------------------------------------------------------------------------
  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mix one command into four pulse widths using the shadow registers.
  function automatic out_item_t mix_pulses(in_item_t cmd);
    int        s, f, t, biggest, power, scaled, center, gain, delta, m;
    int        w[NumWheels];
    int        p[NumWheels];
    out_item_t r;
    s = clip(int'(cmd.strafe_cmd), int'(CmdMin), int'(CmdMax));
    f = clip(int'(cmd.forward_cmd), int'(CmdMin), int'(CmdMax));
    t = clip(int'(cmd.turn_cmd), int'(CmdMin), int'(CmdMax));
    w[0] = f + s + t;
    w[1] = f - s - t;
    w[2] = f - s + t;
    w[3] = f + s - t;
    // normalize only when some wheel exceeds full scale
    biggest = 100;
    for (int i = 0; i < NumWheels; i++) begin
      m = (w[i] < 0) ? -w[i] : w[i];
      if (m > biggest) biggest = m;
    end
    power = clip(int'(power_reg), int'(PowerMin), int'(PowerMax));
    for (int i = 0; i < NumWheels; i++) begin
      scaled = (w[i] * 100) / biggest;             // truncates toward zero
      center = clip(int'(centers_reg[i*PulseW +: PulseW]), int'(CenterMin),
                    int'(CenterMax));
      gain   = clip(int'(gains_reg[i*GainW +: GainW]), int'(GainMin), int'(GainMax));
      delta  = (scaled * power * gain) / 10000;
      if (rev_reg[i]) delta = -delta;
      p[i] = clip(center + delta, int'(PulseMin), int'(PulseMax));
    end
    r.pulse_front_left  = PulseW'(p[0]);
    r.pulse_front_right = PulseW'(p[1]);
    r.pulse_back_left   = PulseW'(p[2]);
    r.pulse_back_right  = PulseW'(p[3]);
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MaxReports) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Command driver: predicts on every accept, then offers the next command
  // unless it rolls an idle cycle. Valid is held steady while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pulses.push_back(mix_pulses(in_data));
        cmds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && (no_gaps || $urandom_range(99) >= IdlePct)) begin
          in_valid <= 1'b1;
          in_data  <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each accepted pulse set is scored field by field against
  // the oldest prediction; ready toggles at random to exercise backpressure.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t         want;
    logic [PulseW-1:0] want_w[NumWheels];
    logic [PulseW-1:0] got_w[NumWheels];
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pulses.size() == 0) begin
          note_error($sformatf("pulse set %0h arrived with no command outstanding",
                               out_data));
        end else begin
          want = expected_pulses.pop_front();
          want_w = '{want.pulse_front_left, want.pulse_front_right,
                     want.pulse_back_left, want.pulse_back_right};
          got_w  = '{out_data.pulse_front_left, out_data.pulse_front_right,
                     out_data.pulse_back_left, out_data.pulse_back_right};
          for (int i = 0; i < NumWheels; i++) begin
            if (got_w[i] !== want_w[i])
              note_error($sformatf("set %0d %s pulse: expected %0d, got %0d",
                                   pulses_checked, wheel_name[i], want_w[i], got_w[i]));
          end
        end
        pulses_checked++;
      end
      out_ready <= no_gaps || ($urandom_range(99) >= IdlePct);
    end
  end

  // --------------------------------------------------------------------------
  // Register access and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // mirror the write; unused indexes change nothing, extra bits are dropped
    case (idx)
      RegCenters:  centers_reg = data[NumWheels*PulseW-1:0];
      RegGains:    gains_reg   = data[NumWheels*GainW-1:0];
      RegReversed: rev_reg     = data[RevW-1:0];
      RegPower:    power_reg   = data[PowerW-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Writes all four registers, with junk above the gains, reversed and power
  // fields, then hits an index past the register list, which must be ignored.
  task automatic set_config(input logic [NumWheels*PulseW-1:0] centers,
                            input logic [NumWheels*GainW-1:0] gains,
                            input logic [RevW-1:0] rev, input logic [PowerW-1:0] power);
    logic [CfgDataW-1:0] data;
    write_reg(RegCenters, centers);
    data = CfgDataW'({$urandom, $urandom});
    data[NumWheels*GainW-1:0] = gains;
    write_reg(RegGains, data);
    data = CfgDataW'({$urandom, $urandom});
    data[RevW-1:0] = rev;
    write_reg(RegReversed, data);
    data = CfgDataW'({$urandom, $urandom});
    data[PowerW-1:0] = power;
    write_reg(RegPower, data);
    write_reg(CfgIdxW'($urandom_range(2**CfgIdxW - 1, NumRegs)),
              CfgDataW'({$urandom, $urandom}));
    settings_used++;
  endtask

  // Mostly legal values, with a share outside the saturation windows.
  task automatic random_config();
    logic [NumWheels*PulseW-1:0] centers;
    logic [NumWheels*GainW-1:0]  gains;
    logic [PowerW-1:0]           power;
    for (int i = 0; i < NumWheels; i++) begin
      centers[i*PulseW +: PulseW] = ($urandom_range(9) < 7) ?
          PulseW'($urandom_range(CenterMax, CenterMin)) : PulseW'($urandom_range(2047, 0));
      gains[i*GainW +: GainW] = ($urandom_range(9) < 7) ?
          GainW'($urandom_range(GainMax, GainMin)) : GainW'($urandom_range(255, 0));
    end
    power = ($urandom_range(9) < 7) ? PowerW'($urandom_range(PowerMax, PowerMin))
                                    : PowerW'($urandom_range(511, 0));
    set_config(centers, gains, RevW'($urandom_range(15, 0)), power);
  endtask

  task automatic queue_cmd(input int s, input int f, input int t);
    in_item_t c;
    c.strafe_cmd  = CmdW'(s);
    c.forward_cmd = CmdW'(f);
    c.turn_cmd    = CmdW'(t);
    pending_cmds.push_back(c);
  endtask

  // A quarter of the values are drawn from the unsaturated window, the rest from the full field.
  function automatic logic signed [CmdW-1:0] random_axis();
    if ($urandom_range(3) == 0) return CmdW'($urandom_range(200) - 100);
    return CmdW'($urandom_range(255));
  endfunction

  task automatic queue_random(input int count);
    in_item_t c;
    for (int n = 0; n < count; n++) begin
      c.strafe_cmd  = random_axis();
      c.forward_cmd = random_axis();
      c.turn_cmd    = random_axis();
      pending_cmds.push_back(c);
    end
  endtask

  // Field extremes, saturation edges, single axes and the mixes that force
  // the normalize-by-largest-wheel path.
  task automatic queue_corner_cmds();
    queue_cmd(0, 0, 0);        queue_cmd(127, 0, 0);      queue_cmd(-128, 0, 0);
    queue_cmd(0, 127, 0);      queue_cmd(0, -128, 0);     queue_cmd(0, 0, 127);
    queue_cmd(0, 0, -128);     queue_cmd(100, 0, 0);      queue_cmd(-100, 0, 0);
    queue_cmd(101, -101, 0);   queue_cmd(0, 100, 100);    queue_cmd(100, 100, 100);
    queue_cmd(-100, -100, -100); queue_cmd(127, 127, 127); queue_cmd(-128, -128, -128);
    queue_cmd(100, -100, 100); queue_cmd(-1, -1, -1);     queue_cmd(1, 1, 1);
    queue_cmd(50, 50, 0);      queue_cmd(33, 33, 34);     queue_cmd(0, -100, 100);
    queue_cmd(127, -128, 127); queue_cmd(-128, 127, -128); queue_cmd(99, 1, 1);
  endtask

  // Wait for every queued command to go in and every pulse set to come out,
  // then give the pipeline a quiet spell before touching registers.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_pulses.size() != 0);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: two front wheels at 1500, backs at 1540, FL and BL reversed
    queue_corner_cmds();
    queue_random(60);
    drain();

    // out-of-window centers and gains at both ends, power above its ceiling
    set_config({11'd1300, 11'd1700, 11'd2047, 11'd0}, {8'd200, 8'd20, 8'd255, 8'd0},
               4'b1010, 9'd511);
    queue_corner_cmds();
    queue_random(40);
    drain();

    // largest swing: full command pushes past 2000, full reverse down to 1100
    set_config({NumWheels{CenterMax}}, {NumWheels{GainMax}}, '0, PowerMax);
    queue_corner_cmds();
    queue_random(40);
    drain();

    // smallest swing, every wheel reversed, power below its floor
    set_config({NumWheels{CenterMin}}, {NumWheels{8'd19}}, '1, 9'd0);
    queue_corner_cmds();
    queue_random(40);
    drain();

    // random settings; one phase runs without any idle cycles
    for (int ph = 0; ph < RandPhases; ph++) begin
      random_config();
      no_gaps = (ph == 3);
      queue_random(RandItems);
      drain();
    end
    no_gaps = 1'b0;

    if (expected_pulses.size() != 0)
      note_error($sformatf("%0d pulse sets never arrived", expected_pulses.size()));

    $display("Scored %0d pulse sets from %0d commands across %0d register settings",
             pulses_checked, cmds_sent, settings_used + 1);
    $display("(%0d register writes, %0d errors)", reg_writes, errors);
    if (errors == 0) begin
      $display("mecanum_mixer_pulse_width verification clean");
    end else begin
      $display("mecanum_mixer_pulse_width verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(TimeoutNs);
    $display("Timeout: %0d commands sent, %0d pulse sets scored", cmds_sent,
             pulses_checked);
    $display("mecanum_mixer_pulse_width verification failed");
    $finish;
  end

endmodule
